// ===== sv/ctb_pkg.sv =====
package ctb_pkg;

    localparam int COUNT_W   = 16;
    localparam int ACTION_W  = 2;
    localparam int IN_IDX_W  = 3;
    localparam int EXP_IDX_W = 3;
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    typedef struct packed {
        logic wr_load;
        logic wr_clear;
        logic tick_init;
        logic advance;
        logic flush;
    } ctb_cmd_t;

    typedef struct packed {
        logic idx_ok;
        logic addr_done;
        logic p_vld;
        logic exp_hit;
        logic pend_vld;
        logic out_full;
    } ctb_stat_t;

endpackage

// ===== sv/countdown_timer_bank.sv =====
// start and stop words keep the bank ready; the timer is written in the accept cycle
// a tick scans one timer per cycle through the single count memory read port,
// holding while an expiry waits on a full output register; no new word is taken
// until the scan and its flush are done. expiries are reported in ascending order,
// the final one of a tick with last set
// reset (aresetn low, synchronous) returns every timer to idle at once through
// per-timer valid bits; no clearing pass
module countdown_timer_bank
    import ctb_pkg::*;
#(
    parameter int NUM_TIMERS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [IN_IDX_W-1:0]  s_timer_index,
    input  logic [COUNT_W-1:0]   s_load_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [EXP_IDX_W-1:0] m_expired_index,
    output logic                 m_last
);

    ctb_cmd_t  cmd;
    ctb_stat_t stat;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_timer_index   (s_timer_index),
        .s_load_count    (s_load_count),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_expired_index (m_expired_index),
        .m_last          (m_last)
    );

endmodule

// ===== sv/ctb_ctrl.sv =====
module ctb_ctrl
    import ctb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  ctb_stat_t           stat,
    output ctb_cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   stall;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    // an expiry needs the pending word moved out, which waits on a full output register
    assign stall   = stat.exp_hit && stat.pend_vld && stat.out_full;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_action)
                        ACT_TICK: begin
                            cmd.tick_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        ACT_START: cmd.wr_load  = stat.idx_ok;
                        ACT_STOP:  cmd.wr_clear = stat.idx_ok;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.advance = !stall;
                if (stat.addr_done && (!stat.p_vld || !stall)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_vld) begin
                    state_next = ST_IDLE;
                end else if (!stat.out_full) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ctb_datapath.sv =====
module ctb_datapath
    import ctb_pkg::*;
#(
    parameter int NUM_TIMERS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IN_IDX_W-1:0]  s_timer_index,
    input  logic [COUNT_W-1:0]   s_load_count,
    input  ctb_cmd_t             cmd,
    output ctb_stat_t            stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [EXP_IDX_W-1:0] m_expired_index,
    output logic                 m_last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    logic [COUNT_W-1:0]   mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] vbits_reg;

    logic [CNT_W-1:0]     addr_reg;
    logic                 p_vld_reg;
    logic [IDX_W-1:0]     p_addr_reg;
    logic [COUNT_W-1:0]   rd_data_reg;
    logic                 rd_vbit_reg;
    logic [RES_CNT_W-1:0] n_reg;
    logic                 pend_vld_reg;
    logic [EXP_IDX_W-1:0] pend_idx_reg;
    logic                 m_valid_reg;
    logic [EXP_IDX_W-1:0] m_idx_reg;
    logic                 m_last_reg;

    logic [COUNT_W-1:0]   cur_count;
    logic                 nonzero;
    logic                 report;
    logic                 proc;
    logic                 wb_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [COUNT_W-1:0]   wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 addr_done;
    logic                 push_mid;
    logic                 push;

    // entries never written read as idle
    assign cur_count = rd_vbit_reg ? rd_data_reg : '0;
    assign nonzero   = (cur_count != '0);
    assign report    = p_vld_reg && (cur_count == COUNT_W'(1))
                       && (n_reg < RES_CNT_W'(MAX_RESULTS));
    assign proc      = cmd.advance && p_vld_reg;
    assign wb_en     = proc && nonzero;

    assign wr_en   = cmd.wr_load || cmd.wr_clear || wb_en;
    assign wr_addr = wb_en ? p_addr_reg : IDX_W'(s_timer_index);
    assign wr_data = wb_en ? (cur_count - COUNT_W'(1))
                           : (cmd.wr_load ? s_load_count : '0);

    assign addr_done = (addr_reg == CNT_W'(NUM_TIMERS));
    assign rd_en     = cmd.advance && !addr_done;
    assign rd_addr   = addr_reg[IDX_W-1:0];

    assign push_mid = proc && report && pend_vld_reg;
    assign push     = push_mid || cmd.flush;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vbit_reg <= vbits_reg[rd_addr];
            p_addr_reg  <= rd_addr;
        end
        if (proc && report) begin
            pend_idx_reg <= EXP_IDX_W'(p_addr_reg);
        end
        if (push) begin
            m_idx_reg  <= pend_idx_reg;
            m_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbits_reg    <= '0;
            addr_reg     <= '0;
            p_vld_reg    <= 1'b0;
            n_reg        <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                vbits_reg[wr_addr] <= 1'b1;
            end
            if (cmd.tick_init) begin
                addr_reg     <= '0;
                p_vld_reg    <= 1'b0;
                n_reg        <= '0;
                pend_vld_reg <= 1'b0;
            end else begin
                if (cmd.advance) begin
                    p_vld_reg <= rd_en;
                end
                if (rd_en) begin
                    addr_reg <= addr_reg + CNT_W'(1);
                end
                if (proc && report) begin
                    n_reg        <= n_reg + RES_CNT_W'(1);
                    pend_vld_reg <= 1'b1;
                end else if (cmd.flush) begin
                    pend_vld_reg <= 1'b0;
                end
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat           = '0;
        stat.idx_ok    = (32'(s_timer_index) < NUM_TIMERS);
        stat.addr_done = addr_done;
        stat.p_vld     = p_vld_reg;
        stat.exp_hit   = report;
        stat.pend_vld  = pend_vld_reg;
        stat.out_full  = m_valid_reg && !m_ready;
    end

    assign m_valid         = m_valid_reg;
    assign m_expired_index = m_idx_reg;
    assign m_last          = m_last_reg;

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !(m_valid_reg && !m_ready))
        else $error("result word overwritten in output register");
    a_n_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("expiry count beyond result limit");
    a_flush_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> pend_vld_reg)
        else $error("flush without pending expiry");
    a_tick_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_init |=> (n_reg == '0) && !pend_vld_reg && !p_vld_reg)
        else $error("scan state not cleared at tick start");
    a_p_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        p_vld_reg |-> (32'(p_addr_reg) < NUM_TIMERS))
        else $error("scan address out of range");
`endif

endmodule
